@@ hdl/ales_pkg.sv @@
// Shared types and constants for the adjacency list edge store.
// No dependencies.
package ales_pkg;

  localparam int unsigned NODE_COUNT = 256;
  localparam int unsigned EDGE_COUNT = 1024;
  localparam int unsigned MAX_WALK   = 63;
  localparam int unsigned LABEL_BITS = 8;

  localparam int unsigned NODE_AW = $clog2(NODE_COUNT);
  localparam int unsigned EDGE_AW = $clog2(EDGE_COUNT);
  localparam int unsigned WALK_W  = $clog2(MAX_WALK + 1);

  typedef enum logic [2:0] {
    KIND_ADD_NODE = 3'd0,
    KIND_ADD_EDGE = 3'd1,
    KIND_TRAV_ALL = 3'd2,
    KIND_TRAV_TYP = 3'd3,
    KIND_DEL_NODE = 3'd4,
    KIND_DEL_EDGE = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FOUND    = 3'd1,
    ST_NOT_USED = 3'd2,
    ST_FULL     = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_LOAD,
    S_TEST,
    S_EDGE,
    S_LINK,
    S_OUT
  } state_e;

  // One edge table entry: next edge (all ones for none), target, label, in-use mark.
  typedef struct packed {
    logic [EDGE_AW:0]      link;
    logic [7:0]            target;
    logic [LABEL_BITS-1:0] label;
    logic                  live;
  } edge_entry_t;

endpackage

@@ hdl/adjacency_list_edge_store.sv @@
// Adjacency list edge store: node heads and edge entries in two synchronous RAMs.
// One command at a time. A simple command goes from idle to the result state, and the
// next command can be accepted once its result is in the output register; delete edge
// first reads and rewrites the entry. A walk tests and reads one link per step, up to
// MAX_WALK links; traverse also outputs each reported neighbor, and output stalls hold it.
// Reset (rst_ni, async low) clears node in-use marks, allocators and control only.
module adjacency_list_edge_store import ales_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  from_node_i,
  input  logic [7:0]  to_node_i,
  input  logic [9:0]  edge_id_i,
  input  logic [7:0]  edge_type_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  node_out_o,
  output logic [9:0]  edge_out_o,
  output logic [7:0]  type_out_o,
  output logic        last_o
);

  // Node in-use marks are flip-flops so reset clears them at once.
  logic [NODE_COUNT-1:0] node_live_q, node_live_d;
  logic [EDGE_AW:0]      node_head_mem [NODE_COUNT];
  edge_entry_t           edge_mem [EDGE_COUNT];

  state_e state_q, state_d;
  logic [NODE_AW:0] node_alloc_q, node_alloc_d;
  logic [EDGE_AW:0] edge_alloc_q, edge_alloc_d;
  logic [2:0] kind_q, kind_d;
  logic [NODE_AW-1:0] from_q, from_d;
  logic [7:0] to_q, to_d;
  logic [LABEL_BITS-1:0] label_q, label_d;
  logic [EDGE_AW:0] cur_q, cur_d;
  logic [EDGE_AW:0] tail_q, tail_d;
  edge_entry_t tail_ent_q, tail_ent_d;
  logic [WALK_W-1:0] reads_q, reads_d;

  // Result waiting for the output register.
  status_e res_status_q, res_status_d;
  logic [7:0] res_node_q, res_node_d;
  logic [EDGE_AW-1:0] res_edge_q, res_edge_d;
  logic [7:0] res_type_q, res_type_d;
  logic res_last_q, res_last_d;

  // Output register.
  logic ovalid_q, ovalid_d;
  status_e ostatus_q, ostatus_d;
  logic [7:0] onode_q, onode_d;
  logic [EDGE_AW-1:0] oedge_q, oedge_d;
  logic [7:0] otype_q, otype_d;
  logic olast_q, olast_d;

  logic [EDGE_AW:0] head_rd_q;
  edge_entry_t edge_rd_q;

  logic head_we, edge_we;
  logic [NODE_AW-1:0] head_wa;
  logic [EDGE_AW:0] head_wd;
  logic [EDGE_AW-1:0] edge_wa, edge_ra;
  edge_entry_t edge_wd;

  logic accept;
  logic from_ok;
  logic cur_ok;
  logic label_match;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign from_ok = ({1'b0, from_node_i[NODE_AW-1:0]} < node_alloc_q);
  // Ids at or above the allocator, including the all-ones none code, end a chain.
  assign cur_ok = (cur_q < edge_alloc_q);
  assign label_match = (kind_q == KIND_TRAV_ALL) || (edge_rd_q.label == label_q);
  assign edge_ra = cur_q[EDGE_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (head_we) node_head_mem[head_wa] <= head_wd;
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    head_rd_q <= node_head_mem[from_q];
    edge_rd_q <= edge_mem[edge_ra];
  end

  always_comb begin
    state_d = state_q;
    node_live_d = node_live_q;
    node_alloc_d = node_alloc_q;
    edge_alloc_d = edge_alloc_q;
    kind_d = kind_q;
    from_d = from_q;
    to_d = to_q;
    label_d = label_q;
    cur_d = cur_q;
    tail_d = tail_q;
    tail_ent_d = tail_ent_q;
    reads_d = reads_q;
    res_status_d = res_status_q;
    res_node_d = res_node_q;
    res_edge_d = res_edge_q;
    res_type_d = res_type_q;
    res_last_d = res_last_q;
    ovalid_d = ovalid_q && out_stall_i;
    ostatus_d = ostatus_q;
    onode_d = onode_q;
    oedge_d = oedge_q;
    otype_d = otype_q;
    olast_d = olast_q;
    head_we = 1'b0;
    head_wa = from_q;
    head_wd = '1;
    edge_we = 1'b0;
    edge_wa = edge_alloc_q[EDGE_AW-1:0];
    edge_wd.link = '1;
    edge_wd.target = to_q;
    edge_wd.label = label_q;
    edge_wd.live = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d = kind_i;
          from_d = from_node_i[NODE_AW-1:0];
          to_d = to_node_i;
          label_d = edge_type_i[LABEL_BITS-1:0];
          reads_d = '0;
          tail_d = '1;
          res_status_d = ST_DONE;
          res_node_d = '0;
          res_edge_d = '0;
          res_type_d = '0;
          res_last_d = 1'b1;
          state_d = S_OUT;
          case (kind_i)
            KIND_ADD_NODE: begin
              if (node_alloc_q >= (NODE_AW+1)'(NODE_COUNT)) begin
                res_status_d = ST_FULL;
              end else begin
                node_live_d[node_alloc_q[NODE_AW-1:0]] = 1'b1;
                head_we = 1'b1;
                head_wa = node_alloc_q[NODE_AW-1:0];
                res_node_d = 8'(node_alloc_q);
                node_alloc_d = node_alloc_q + (NODE_AW+1)'(1);
              end
            end
            KIND_ADD_EDGE: begin
              if (edge_alloc_q >= (EDGE_AW+1)'(EDGE_COUNT)) res_status_d = ST_FULL;
              else if (!from_ok) res_status_d = ST_NOT_USED;
              else state_d = S_HEAD;
            end
            KIND_TRAV_ALL, KIND_TRAV_TYP: begin
              if (!from_ok || !node_live_q[from_node_i[NODE_AW-1:0]]) begin
                res_status_d = ST_NOT_USED;
              end else begin
                state_d = S_HEAD;
              end
            end
            KIND_DEL_NODE: begin
              if (!from_ok) res_status_d = ST_NOT_USED;
              else node_live_d[from_node_i[NODE_AW-1:0]] = 1'b0;
            end
            KIND_DEL_EDGE: begin
              // Only an edge already handed out is read back and rewritten.
              if ({1'b0, edge_id_i} < edge_alloc_q) begin
                cur_d = {1'b0, edge_id_i};
                state_d = S_TEST;
              end
            end
            default: ;
          endcase
        end
      end
      S_HEAD: state_d = S_LOAD;
      S_LOAD: begin
        cur_d = head_rd_q;
        state_d = S_TEST;
      end
      S_TEST: begin
        case (kind_q)
          KIND_ADD_EDGE: begin
            if (!cur_ok) begin
              // Tail reached: write the new entry, then hook it to the head or the tail.
              edge_we = 1'b1;
              if (tail_q == '1) begin
                head_we = 1'b1;
                head_wd = edge_alloc_q;
                res_edge_d = edge_alloc_q[EDGE_AW-1:0];
                res_type_d = 8'(label_q);
                edge_alloc_d = edge_alloc_q + (EDGE_AW+1)'(1);
                state_d = S_OUT;
              end else begin
                state_d = S_LINK;
              end
            end else if (reads_q == WALK_W'(MAX_WALK)) begin
              res_status_d = ST_TOO_LONG;
              state_d = S_OUT;
            end else begin
              state_d = S_EDGE;
            end
          end
          KIND_DEL_EDGE: state_d = S_EDGE;
          default: begin
            if (cur_ok && reads_q != WALK_W'(MAX_WALK)) begin
              state_d = S_EDGE;
            end else begin
              if (cur_ok) res_status_d = ST_TOO_LONG;
              else res_status_d = ST_DONE;
              res_node_d = '0;
              res_edge_d = '0;
              res_type_d = '0;
              res_last_d = 1'b1;
              state_d = S_OUT;
            end
          end
        endcase
      end
      S_EDGE: begin
        case (kind_q)
          KIND_ADD_EDGE: begin
            reads_d = reads_q + WALK_W'(1);
            tail_d = cur_q;
            tail_ent_d = edge_rd_q;
            cur_d = edge_rd_q.link;
            state_d = S_TEST;
          end
          KIND_DEL_EDGE: begin
            edge_we = 1'b1;
            edge_wa = cur_q[EDGE_AW-1:0];
            edge_wd = edge_rd_q;
            edge_wd.live = 1'b0;
            state_d = S_OUT;
          end
          default: begin
            reads_d = reads_q + WALK_W'(1);
            cur_d = edge_rd_q.link;
            if (edge_rd_q.live && label_match) begin
              res_status_d = ST_FOUND;
              res_node_d = edge_rd_q.target;
              res_edge_d = cur_q[EDGE_AW-1:0];
              res_type_d = 8'(edge_rd_q.label);
              res_last_d = 1'b0;
              state_d = S_OUT;
            end else begin
              state_d = S_TEST;
            end
          end
        endcase
      end
      S_LINK: begin
        edge_we = 1'b1;
        edge_wa = tail_q[EDGE_AW-1:0];
        edge_wd = tail_ent_q;
        edge_wd.link = edge_alloc_q;
        res_edge_d = edge_alloc_q[EDGE_AW-1:0];
        res_type_d = 8'(label_q);
        edge_alloc_d = edge_alloc_q + (EDGE_AW+1)'(1);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          ostatus_d = res_status_q;
          onode_d = res_node_q;
          oedge_d = res_edge_q;
          otype_d = res_type_q;
          olast_d = res_last_q;
          if (res_last_q) state_d = S_IDLE;
          else state_d = S_TEST;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      node_live_q <= '0;
      node_alloc_q <= '0;
      edge_alloc_q <= '0;
      kind_q <= '0;
      from_q <= '0;
      to_q <= '0;
      label_q <= '0;
      cur_q <= '0;
      tail_q <= '1;
      tail_ent_q <= '0;
      reads_q <= '0;
      res_status_q <= ST_DONE;
      res_node_q <= '0;
      res_edge_q <= '0;
      res_type_q <= '0;
      res_last_q <= 1'b0;
      ovalid_q <= 1'b0;
      ostatus_q <= ST_DONE;
      onode_q <= '0;
      oedge_q <= '0;
      otype_q <= '0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      node_live_q <= node_live_d;
      node_alloc_q <= node_alloc_d;
      edge_alloc_q <= edge_alloc_d;
      kind_q <= kind_d;
      from_q <= from_d;
      to_q <= to_d;
      label_q <= label_d;
      cur_q <= cur_d;
      tail_q <= tail_d;
      tail_ent_q <= tail_ent_d;
      reads_q <= reads_d;
      res_status_q <= res_status_d;
      res_node_q <= res_node_d;
      res_edge_q <= res_edge_d;
      res_type_q <= res_type_d;
      res_last_q <= res_last_d;
      ovalid_q <= ovalid_d;
      ostatus_q <= ostatus_d;
      onode_q <= onode_d;
      oedge_q <= oedge_d;
      otype_q <= otype_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign status_o = ostatus_q;
  assign node_out_o = onode_q;
  assign edge_out_o = oedge_q;
  assign type_out_o = otype_q;
  assign last_o = olast_q;

endmodule

@@ verif/ales_checker.sv @@
// Checker for the adjacency list edge store: watches both channels, keeps its
// own copy of the node and edge tables and compares every result in order.
// Depends on ales_pkg for the command and status codes and the table sizes.
`timescale 1ns / 1ps

module ales_checker import ales_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] from_node_i,
  input  logic [7:0] to_node_i,
  input  logic [9:0] edge_id_i,
  input  logic [7:0] edge_type_i,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic [2:0] status_o,
  input  logic [7:0] node_out_o,
  input  logic [9:0] edge_out_o,
  input  logic [7:0] type_out_o,
  input  logic       last_o,
  output int         mismatches,
  output int         outstanding,
  output int         commands_seen,
  output int         results_seen
);

  localparam int NONE = -1;
  localparam logic [7:0] LABEL_MASK = 8'((64'd1 << LABEL_BITS) - 1);

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] node;
    logic [9:0] edge_num;
    logic [7:0] label;
    logic       last;
  } result_t;

  result_t    expected_results[$];
  bit         node_live[NODE_COUNT];
  int         node_head[NODE_COUNT];
  logic [7:0] edge_target[EDGE_COUNT];
  int         edge_link[EDGE_COUNT];
  bit         edge_live[EDGE_COUNT];
  logic [7:0] edge_label[EDGE_COUNT];
  int         node_alloc;
  int         edge_alloc;

  function automatic bit edge_in_table(int e);
    return e >= 0 && e < edge_alloc && e < EDGE_COUNT;
  endfunction

  task automatic expect_result(status_e s, int node, int e, logic [7:0] label, bit last);
    result_t r;
    r.status = s;
    r.node = node[7:0];
    r.edge_num = e[9:0];
    r.label = label;
    r.last = last;
    expected_results.push_back(r);
  endtask

  task automatic apply_command(logic [2:0] kind, logic [7:0] src, logic [7:0] dst,
                               logic [9:0] eid, logic [7:0] typ);
    logic [7:0] label;
    bit src_ok;
    int cur;
    int tail;
    int reads;
    label = typ & LABEL_MASK;
    src_ok = int'(src) < node_alloc;
    case (kind)
      KIND_ADD_NODE: begin
        if (node_alloc >= NODE_COUNT) begin
          expect_result(ST_FULL, 0, 0, 8'd0, 1'b1);
        end else begin
          node_live[node_alloc] = 1'b1;
          node_head[node_alloc] = NONE;
          expect_result(ST_DONE, node_alloc, 0, 8'd0, 1'b1);
          node_alloc++;
        end
      end
      KIND_ADD_EDGE: begin
        if (edge_alloc >= EDGE_COUNT) begin
          expect_result(ST_FULL, 0, 0, 8'd0, 1'b1);
        end else if (!src_ok) begin
          expect_result(ST_NOT_USED, 0, 0, 8'd0, 1'b1);
        end else begin
          cur = node_head[src];
          tail = NONE;
          reads = 0;
          while (edge_in_table(cur) && reads < MAX_WALK) begin
            reads++;
            tail = cur;
            cur = edge_link[cur];
          end
          if (edge_in_table(cur)) begin
            expect_result(ST_TOO_LONG, 0, 0, 8'd0, 1'b1);
          end else begin
            edge_target[edge_alloc] = dst;
            edge_label[edge_alloc] = label;
            edge_link[edge_alloc] = NONE;
            edge_live[edge_alloc] = 1'b1;
            if (tail == NONE) node_head[src] = edge_alloc;
            else edge_link[tail] = edge_alloc;
            expect_result(ST_DONE, 0, edge_alloc, label, 1'b1);
            edge_alloc++;
          end
        end
      end
      KIND_TRAV_ALL, KIND_TRAV_TYP: begin
        if (!src_ok || !node_live[src]) begin
          expect_result(ST_NOT_USED, 0, 0, 8'd0, 1'b1);
        end else begin
          cur = node_head[src];
          reads = 0;
          while (edge_in_table(cur) && reads < MAX_WALK) begin
            reads++;
            if (edge_live[cur] && (kind == KIND_TRAV_ALL || edge_label[cur] == label))
              expect_result(ST_FOUND, edge_target[cur], cur, edge_label[cur], 1'b0);
            cur = edge_link[cur];
          end
          expect_result(edge_in_table(cur) ? ST_TOO_LONG : ST_DONE, 0, 0, 8'd0, 1'b1);
        end
      end
      KIND_DEL_NODE: begin
        if (!src_ok) begin
          expect_result(ST_NOT_USED, 0, 0, 8'd0, 1'b1);
        end else begin
          node_live[src] = 1'b0;
          expect_result(ST_DONE, 0, 0, 8'd0, 1'b1);
        end
      end
      default: begin
        // Deleting an edge that was never handed out changes nothing.
        if (kind == KIND_DEL_EDGE && edge_in_table(int'(eid))) edge_live[eid] = 1'b0;
        expect_result(ST_DONE, 0, 0, 8'd0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      for (int i = 0; i < NODE_COUNT; i++) node_live[i] = 1'b0;
      node_alloc = 0;
      edge_alloc = 0;
      mismatches = 0;
      commands_seen = 0;
      results_seen = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_command(kind_i, from_node_i, to_node_i, edge_id_i, edge_type_i);
        commands_seen++;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result status=%0d node=%0d edge=%0d type=%0d last=%0d",
                   $time, status_o, node_out_o, edge_out_o, type_out_o, last_o);
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          end
          if (node_out_o !== want.node) begin
            mismatches++;
            $display("%0t: node_out expected %0d actual %0d", $time, want.node, node_out_o);
          end
          if (edge_out_o !== want.edge_num) begin
            mismatches++;
            $display("%0t: edge_out expected %0d actual %0d", $time, want.edge_num,
                     edge_out_o);
          end
          if (type_out_o !== want.label) begin
            mismatches++;
            $display("%0t: type_out expected %0d actual %0d", $time, want.label, type_out_o);
          end
          if (last_o !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0d actual %0d", $time, want.last, last_o);
          end
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

@@ verif/adjacency_list_edge_store_test.sv @@
// Top of the edge store testbench: clock, reset, command stimulus, result
// backpressure and the verdict. Depends on ales_pkg, the store and ales_checker.
`timescale 1ns / 1ps

module adjacency_list_edge_store_test;
  import ales_pkg::*;

  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 90;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] kind_i = '0;
  logic [7:0] from_node_i = '0;
  logic [7:0] to_node_i = '0;
  logic [9:0] edge_id_i = '0;
  logic [7:0] edge_type_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [7:0] node_out_o;
  logic [9:0] edge_out_o;
  logic [7:0] type_out_o;
  logic       last_o;

  int mismatches;
  int outstanding;
  int commands_seen;
  int results_seen;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_started = 1'b0;
  int hold_count = 0;
  int run_left = 0;
  int idle_cycles = 0;
  int nodes_made = 0;

  adjacency_list_edge_store uut (.*);

  ales_checker chk (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_source();
    if (nodes_made > 0 && $urandom_range(0, 99) < 85)
      return 8'($urandom_range(0, nodes_made - 1));
    return 8'($urandom);
  endfunction

  // Result side: random stalls, plus one long hold-off counted here.
  always @(posedge clk_i) begin
    if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_count <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_count > 0) begin
      hold_count <= hold_count - 1;
      out_stall_i <= (hold_count > 1);
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
    end else begin
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
      run_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL adjacency_list_edge_store");
      $finish;
    end
  end

  task automatic issue(logic [2:0] kind, logic [7:0] src, logic [7:0] dst,
                       logic [9:0] eid, logic [7:0] typ);
    int gap;
    kind_i <= kind;
    from_node_i <= src;
    to_node_i <= dst;
    edge_id_i <= eid;
    edge_type_i <= typ;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == KIND_ADD_NODE && nodes_made < NODE_COUNT) nodes_made++;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lets every expected result arrive, then a little longer.
  task automatic drain(int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (settle) @(posedge clk_i);
  endtask

  initial begin
    int r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands over the special cases.
    issue(KIND_ADD_NODE, 8'd0, 8'd0, 10'd0, 8'd0);
    issue(KIND_ADD_NODE, 8'hFF, 8'hFF, 10'h3FF, 8'hFF);
    issue(KIND_ADD_NODE, 8'd0, 8'd0, 10'd0, 8'd0);
    issue(KIND_ADD_EDGE, 8'd0, 8'd255, 10'd0, 8'd0);
    issue(KIND_ADD_EDGE, 8'd0, 8'd0, 10'h3FF, 8'd255);
    issue(KIND_ADD_EDGE, 8'd200, 8'd1, 10'd0, 8'd1);
    issue(KIND_TRAV_ALL, 8'd0, 8'd0, 10'd0, 8'd0);
    issue(KIND_TRAV_TYP, 8'd0, 8'd0, 10'd0, 8'd255);
    issue(KIND_TRAV_TYP, 8'd0, 8'd0, 10'd0, 8'd7);
    issue(KIND_TRAV_ALL, 8'd250, 8'd0, 10'd0, 8'd0);
    issue(KIND_DEL_EDGE, 8'd0, 8'd0, 10'd0, 8'd0);
    issue(KIND_DEL_EDGE, 8'd0, 8'd0, 10'd1023, 8'd0);
    issue(KIND_DEL_EDGE, 8'd0, 8'd0, 10'd0, 8'd0);
    issue(KIND_TRAV_ALL, 8'd0, 8'd0, 10'd0, 8'd0);
    issue(KIND_ADD_EDGE, 8'd1, 8'd2, 10'd0, 8'd3);
    issue(KIND_DEL_NODE, 8'd1, 8'd0, 10'd0, 8'd0);
    issue(KIND_DEL_NODE, 8'd1, 8'd0, 10'd0, 8'd0);
    issue(KIND_TRAV_ALL, 8'd1, 8'd0, 10'd0, 8'd0);
    issue(KIND_ADD_EDGE, 8'd1, 8'd9, 10'd0, 8'd4);
    issue(KIND_DEL_NODE, 8'd255, 8'd0, 10'd0, 8'd0);
    issue(KIND_SPARE_A, 8'($urandom), 8'($urandom), 10'($urandom), 8'($urandom));
    issue(KIND_SPARE_B, 8'($urandom), 8'($urandom), 10'($urandom), 8'($urandom));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet <= (i % 40) >= 30;
      if (i == RANDOM_ITEMS / 2) drain(150);
      r = $urandom_range(0, 99);
      if (r < 15)
        issue(KIND_ADD_NODE, 8'($urandom), 8'($urandom), 10'($urandom), 8'($urandom));
      else if (r < 50)
        issue(KIND_ADD_EDGE, pick_source(), 8'($urandom), 10'($urandom),
              $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom));
      else if (r < 65)
        issue(KIND_TRAV_ALL, pick_source(), 8'($urandom), 10'($urandom), 8'($urandom));
      else if (r < 75)
        issue(KIND_TRAV_TYP, pick_source(), 8'($urandom), 10'($urandom),
              $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom));
      else if (r < 80)
        issue(KIND_DEL_NODE, pick_source(), 8'($urandom), 10'($urandom), 8'($urandom));
      else if (r < 88)
        issue(KIND_DEL_EDGE, pick_source(), 8'($urandom),
              $urandom_range(0, 1) ? 10'($urandom_range(0, 150)) : 10'($urandom),
              8'($urandom));
      else
        issue(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 10'($urandom),
              8'($urandom));
    end
    quiet <= 1'b0;

    // Fill the node table and run past its end.
    while (nodes_made < NODE_COUNT)
      issue(KIND_ADD_NODE, 8'($urandom), 8'($urandom), 10'($urandom), 8'($urandom));
    repeat (2) issue(KIND_ADD_NODE, 8'($urandom), 8'($urandom), 10'($urandom), 8'($urandom));

    // Grow the last node's chain to the walk limit and then past it.
    repeat (MAX_WALK + 3)
      issue(KIND_ADD_EDGE, 8'(NODE_COUNT - 1), 8'($urandom), 10'($urandom),
            8'($urandom_range(0, 3)));
    drain(150);

    // Long result hold-off while full-length traversals keep coming.
    hold_req <= 1'b1;
    for (int k = 0; k < 8; k++)
      issue(k % 2 ? KIND_TRAV_TYP : KIND_TRAV_ALL, 8'(NODE_COUNT - 1), 8'($urandom),
            10'($urandom), 8'($urandom_range(0, 3)));

    in_valid_i <= 1'b0;
    drain(200);
    $display("Ran %0d commands giving %0d results, through a full node table,",
             commands_seen, results_seen);
    $display("chains past the walk limit, deletes and a long result hold-off.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS adjacency_list_edge_store");
    end else begin
      $display("FAIL adjacency_list_edge_store");
    end
    $finish;
  end

endmodule

@@ adjacency_list_edge_store.f @@
hdl/ales_pkg.sv
hdl/adjacency_list_edge_store.sv
verif/ales_checker.sv
verif/adjacency_list_edge_store_test.sv
